### design/pskd_pkg.sv
package pskd_pkg;

   // Scan code set 2 prefix and special key bytes
   localparam logic [7:0] CODE_BREAK  = 8'hf0;
   localparam logic [7:0] CODE_EXT    = 8'he0;
   localparam logic [7:0] CODE_LSHIFT = 8'h12;
   localparam logic [7:0] CODE_RSHIFT = 8'h59;
   localparam logic [7:0] CODE_CTRL   = 8'h14;
   localparam logic [7:0] CODE_CAPS   = 8'h58;
   localparam logic [7:0] CODE_SCROLL = 8'h7e;
   localparam logic [7:0] CODE_NUM    = 8'h77;

   // Prefix phases
   localparam logic [1:0] PHASE_MAKE      = 2'd0;
   localparam logic [1:0] PHASE_BREAK     = 2'd1;
   localparam logic [1:0] PHASE_EXT_MAKE  = 2'd2;
   localparam logic [1:0] PHASE_EXT_BREAK = 2'd3;

   // Modifier bit positions
   localparam int MOD_LSHIFT = 0;
   localparam int MOD_RSHIFT = 1;
   localparam int MOD_LCTRL  = 2;
   localparam int MOD_RCTRL  = 3;

   // Lock bit positions
   localparam int LOCK_CAPS   = 0;
   localparam int LOCK_NUM    = 1;
   localparam int LOCK_SCROLL = 2;

   localparam logic [2:0] LOCK_RESET = 3'b010;

   // Output column codes
   localparam logic [1:0] COL_NORMAL = 2'd0;
   localparam logic [1:0] COL_CAPS   = 2'd1;
   localparam logic [1:0] COL_SHIFT  = 2'd2;

   localparam int QUEUE_DEPTH = 2;

   // Classified key event passed from front to back
   typedef struct packed {
      logic [5:0] row;
      logic       down;
      logic       shift;
      logic       ctrl;
      logic [2:0] locks;
   } key_event_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] row;
   } lookup_type;

   // Fixed scan code table
   function automatic lookup_type scan_lookup(input logic [7:0] code);
      lookup_type res;
      res.hit = 1'b1;
      res.row = 6'd0;
      case (code)
         8'h1c: res.row = 6'd0;
         8'h32: res.row = 6'd1;
         8'h21: res.row = 6'd2;
         8'h23: res.row = 6'd3;
         8'h24: res.row = 6'd4;
         8'h2b: res.row = 6'd5;
         8'h34: res.row = 6'd6;
         8'h33: res.row = 6'd7;
         8'h43: res.row = 6'd8;
         8'h3b: res.row = 6'd9;
         8'h42: res.row = 6'd10;
         8'h4b: res.row = 6'd11;
         8'h3a: res.row = 6'd12;
         8'h31: res.row = 6'd13;
         8'h44: res.row = 6'd14;
         8'h4d: res.row = 6'd15;
         8'h15: res.row = 6'd16;
         8'h2d: res.row = 6'd17;
         8'h1b: res.row = 6'd18;
         8'h2c: res.row = 6'd19;
         8'h3c: res.row = 6'd20;
         8'h2a: res.row = 6'd21;
         8'h1d: res.row = 6'd22;
         8'h22: res.row = 6'd23;
         8'h35: res.row = 6'd24;
         8'h1a: res.row = 6'd25;
         8'h45: res.row = 6'd26;
         8'h16: res.row = 6'd27;
         8'h1e: res.row = 6'd28;
         8'h26: res.row = 6'd29;
         8'h25: res.row = 6'd30;
         8'h2e: res.row = 6'd31;
         8'h36: res.row = 6'd32;
         8'h3d: res.row = 6'd33;
         8'h3e: res.row = 6'd34;
         8'h46: res.row = 6'd35;
         8'h29: res.row = 6'd36;
         8'h52: res.row = 6'd37;
         8'h55: res.row = 6'd38;
         8'h41: res.row = 6'd39;
         8'h4e: res.row = 6'd40;
         8'h49: res.row = 6'd41;
         8'h4a: res.row = 6'd42;
         8'h4c: res.row = 6'd43;
         8'h54: res.row = 6'd44;
         8'h5d: res.row = 6'd45;
         8'h5b: res.row = 6'd46;
         8'h0e: res.row = 6'd47;
         8'h75: res.row = 6'd48;
         8'h72: res.row = 6'd49;
         8'h6b: res.row = 6'd50;
         8'h74: res.row = 6'd51;
         8'h0d: res.row = 6'd52;
         8'h66: res.row = 6'd53;
         8'h5a: res.row = 6'd54;
         8'h6c: res.row = 6'd55;
         8'h69: res.row = 6'd56;
         8'h76: res.row = 6'd57;
         8'h37: res.row = 6'd58;
         default: res.hit = 1'b0;
      endcase
      return res;
   endfunction

endpackage

### design/ps2_scancode_key_decoder.sv
// PS/2 scan code set 2 key decoder. One keyboard byte is taken per cycle on
// the req_ channel while req_stall is low; prefix bytes, shift/ctrl and lock
// keys only update state, while a key byte found in the 59-entry code table
// yields one rsp_ transaction carrying the table row, the column (caps, else
// shift, else normal), the press/release flag and the lock states. Unknown
// codes, and keys with ctrl held and neither caps nor shift, yield nothing. A
// result reaches rsp_ through a two-entry event queue and the output register.
// req_stall rises only while that queue is full, so the block sustains one
// byte per cycle as long as results are taken. Num lock is on after reset.
module ps2_scancode_key_decoder import pskd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_scan_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [5:0] rsp_key_row,
   output logic [1:0] rsp_key_column,
   output logic       rsp_key_pressed,
   output logic       rsp_caps_state,
   output logic       rsp_num_state,
   output logic       rsp_scroll_state
);

   logic          accept;
   logic          push;
   logic          pop;
   logic          full;
   logic          not_empty;
   key_event_type push_event;
   key_event_type head_event;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   // Decode front end
   pskd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .scan_byte  (req_scan_byte),
      .push       (push),
      .push_event (push_event)
   );

   // Event queue
   pskd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_event (push_event),
      .pop        (pop),
      .full       (full),
      .not_empty  (not_empty),
      .head_event (head_event)
   );

   // Result stage
   pskd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .not_empty        (not_empty),
      .head_event       (head_event),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_key_row      (rsp_key_row),
      .rsp_key_column   (rsp_key_column),
      .rsp_key_pressed  (rsp_key_pressed),
      .rsp_caps_state   (rsp_caps_state),
      .rsp_num_state    (rsp_num_state),
      .rsp_scroll_state (rsp_scroll_state)
   );

endmodule

### design/pskd_front.sv
module pskd_front import pskd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    scan_byte,
   output logic          push,
   output key_event_type push_event
);

   logic [1:0] phase_ff, phase_in;
   logic [3:0] mod_ff, mod_in;
   logic [2:0] lock_ff, lock_in;
   logic       emit;
   logic       down;
   logic       is_prefix;
   lookup_type hit;

   assign is_prefix = (scan_byte == CODE_BREAK) || (scan_byte == CODE_EXT);
   assign hit       = scan_lookup(scan_byte);

   // Prefix phase, modifier and lock tracking
   always_comb begin
      phase_in = phase_ff;
      mod_in   = mod_ff;
      lock_in  = lock_ff;
      emit     = 1'b0;
      down     = 1'b0;
      case (phase_ff)
         PHASE_MAKE: begin
            if (scan_byte == CODE_BREAK) begin
               phase_in = PHASE_BREAK;
            end else if (scan_byte == CODE_EXT) begin
               phase_in = PHASE_EXT_MAKE;
            end else if (scan_byte == CODE_LSHIFT) begin
               mod_in[MOD_LSHIFT] = 1'b1;
            end else if (scan_byte == CODE_RSHIFT) begin
               mod_in[MOD_RSHIFT] = 1'b1;
            end else if (scan_byte == CODE_CTRL) begin
               mod_in[MOD_LCTRL] = 1'b1;
            end else if (scan_byte == CODE_CAPS) begin
               lock_in[LOCK_CAPS] = ~lock_ff[LOCK_CAPS];
            end else if (scan_byte == CODE_SCROLL) begin
               lock_in[LOCK_SCROLL] = ~lock_ff[LOCK_SCROLL];
            end else if (scan_byte == CODE_NUM) begin
               lock_in[LOCK_NUM] = ~lock_ff[LOCK_NUM];
            end else begin
               emit = 1'b1;
               down = 1'b1;
            end
         end
         PHASE_BREAK: begin
            if (!is_prefix) begin
               phase_in = PHASE_MAKE;
               if (scan_byte == CODE_LSHIFT) begin
                  mod_in[MOD_LSHIFT] = 1'b0;
               end else if (scan_byte == CODE_RSHIFT) begin
                  mod_in[MOD_RSHIFT] = 1'b0;
               end else if (scan_byte == CODE_CTRL) begin
                  mod_in[MOD_LCTRL] = 1'b0;
               end else begin
                  emit = 1'b1;
               end
            end
         end
         PHASE_EXT_MAKE: begin
            if (is_prefix) begin
               phase_in = PHASE_EXT_BREAK;
            end else begin
               phase_in = PHASE_MAKE;
               if (scan_byte == CODE_CTRL) begin
                  mod_in[MOD_RCTRL] = 1'b1;
               end else begin
                  emit = 1'b1;
                  down = 1'b1;
               end
            end
         end
         default: begin
            if (!is_prefix) begin
               phase_in = PHASE_MAKE;
               if (scan_byte == CODE_CTRL) begin
                  mod_in[MOD_RCTRL] = 1'b0;
               end else begin
                  emit = 1'b1;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_MAKE;
         mod_ff   <= '0;
         lock_ff  <= LOCK_RESET;
      end else if (accept) begin
         phase_ff <= phase_in;
         mod_ff   <= mod_in;
         lock_ff  <= lock_in;
      end
   end

   // Only table hits enter the queue; state before this byte is snapshotted
   assign push             = accept && emit && hit.hit;
   assign push_event.row   = hit.row;
   assign push_event.down  = down;
   assign push_event.shift = mod_ff[MOD_LSHIFT] | mod_ff[MOD_RSHIFT];
   assign push_event.ctrl  = mod_ff[MOD_LCTRL] | mod_ff[MOD_RCTRL];
   assign push_event.locks = lock_ff;

endmodule

### design/pskd_queue.sv
module pskd_queue import pskd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  key_event_type push_event,
   input  logic          pop,
   output logic          full,
   output logic          not_empty,
   output key_event_type head_event
);

   key_event_type entry_ff [QUEUE_DEPTH];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   assign full       = (count_ff == 2'(QUEUE_DEPTH));
   assign not_empty  = (count_ff != 2'd0);
   assign head_event = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_event;
      end
   end

endmodule

### design/pskd_back.sv
module pskd_back import pskd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          not_empty,
   input  key_event_type head_event,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [5:0]    rsp_key_row,
   output logic [1:0]    rsp_key_column,
   output logic          rsp_key_pressed,
   output logic          rsp_caps_state,
   output logic          rsp_num_state,
   output logic          rsp_scroll_state
);

   logic       valid_ff, valid_in;
   logic [5:0] row_ff;
   logic [1:0] column_ff, column_in;
   logic       pressed_ff;
   logic [2:0] locks_ff;
   logic       suppress;

   // Column selection: caps first, then shift; ctrl alone drops the event
   always_comb begin
      suppress  = 1'b0;
      column_in = COL_NORMAL;
      if (head_event.locks[LOCK_CAPS]) begin
         column_in = COL_CAPS;
      end else if (head_event.shift) begin
         column_in = COL_SHIFT;
      end else if (head_event.ctrl) begin
         suppress = 1'b1;
      end
   end

   assign pop = not_empty && (!valid_ff || !rsp_stall);

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = !suppress;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      if (pop) begin
         row_ff     <= head_event.row;
         column_ff  <= column_in;
         pressed_ff <= head_event.down;
         locks_ff   <= head_event.locks;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_key_row      = row_ff;
   assign rsp_key_column   = column_ff;
   assign rsp_key_pressed  = pressed_ff;
   assign rsp_caps_state   = locks_ff[LOCK_CAPS];
   assign rsp_num_state    = locks_ff[LOCK_NUM];
   assign rsp_scroll_state = locks_ff[LOCK_SCROLL];

endmodule

### sim/pskd_key_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the scan code decoder, predicts the key event
// for every accepted byte and compares each result transaction in order.
module pskd_key_checker import pskd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_scan_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [5:0] rsp_key_row,
   input  logic [1:0] rsp_key_column,
   input  logic       rsp_key_pressed,
   input  logic       rsp_caps_state,
   input  logic       rsp_num_state,
   input  logic       rsp_scroll_state,
   output int         mismatches,
   output int         pending,
   output int         events_checked
);

   typedef struct packed {
      logic [5:0] row;
      logic [1:0] column;
      logic       pressed;
      logic       caps;
      logic       num;
      logic       scroll;
   } key_report_type;

   localparam int KEY_ROWS = 59;

   // Scan code set 2 key codes, in row order
   localparam logic [7:0] KEY_CODES [KEY_ROWS] = '{
      8'h1c, 8'h32, 8'h21, 8'h23, 8'h24, 8'h2b, 8'h34, 8'h33, 8'h43, 8'h3b,
      8'h42, 8'h4b, 8'h3a, 8'h31, 8'h44, 8'h4d, 8'h15, 8'h2d, 8'h1b, 8'h2c,
      8'h3c, 8'h2a, 8'h1d, 8'h22, 8'h35, 8'h1a, 8'h45, 8'h16, 8'h1e, 8'h26,
      8'h25, 8'h2e, 8'h36, 8'h3d, 8'h3e, 8'h46, 8'h29, 8'h52, 8'h55, 8'h41,
      8'h4e, 8'h49, 8'h4a, 8'h4c, 8'h54, 8'h5d, 8'h5b, 8'h0e, 8'h75, 8'h72,
      8'h6b, 8'h74, 8'h0d, 8'h66, 8'h5a, 8'h6c, 8'h69, 8'h76, 8'h37
   };

   logic [1:0]     phase_q;
   logic [3:0]     mods_q;
   logic [2:0]     locks_q;
   key_report_type key_events_q [$];

   function automatic bit find_row(input logic [7:0] code, output logic [5:0] row);
      row = '0;
      for (int i = 0; i < KEY_ROWS; i++) begin
         if (KEY_CODES[i] == code) begin
            row = 6'(i);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Table hit gives an event unless ctrl alone is held
   function automatic bit key_event(input logic [7:0] code, input logic down,
                                    output key_report_type ev);
      logic [5:0] row;
      ev = '0;
      if (!find_row(code, row)) return 1'b0;
      if (locks_q[LOCK_CAPS]) ev.column = COL_CAPS;
      else if (mods_q[MOD_LSHIFT] || mods_q[MOD_RSHIFT]) ev.column = COL_SHIFT;
      else if (mods_q[MOD_LCTRL] || mods_q[MOD_RCTRL]) return 1'b0;
      else ev.column = COL_NORMAL;
      ev.row     = row;
      ev.pressed = down;
      ev.caps    = locks_q[LOCK_CAPS];
      ev.num     = locks_q[LOCK_NUM];
      ev.scroll  = locks_q[LOCK_SCROLL];
      return 1'b1;
   endfunction

   // Prefix phase, modifier and lock tracking for one received byte
   function automatic bit decode_byte(input logic [7:0] b, output key_report_type ev);
      logic is_prefix;
      bit   hit;
      is_prefix = (b == CODE_BREAK) || (b == CODE_EXT);
      hit = 1'b0;
      ev = '0;
      case (phase_q)
         PHASE_MAKE: begin
            if (b == CODE_BREAK) phase_q = PHASE_BREAK;
            else if (b == CODE_EXT) phase_q = PHASE_EXT_MAKE;
            else if (b == CODE_LSHIFT) mods_q[MOD_LSHIFT] = 1'b1;
            else if (b == CODE_RSHIFT) mods_q[MOD_RSHIFT] = 1'b1;
            else if (b == CODE_CTRL) mods_q[MOD_LCTRL] = 1'b1;
            else if (b == CODE_CAPS) locks_q[LOCK_CAPS] = ~locks_q[LOCK_CAPS];
            else if (b == CODE_SCROLL) locks_q[LOCK_SCROLL] = ~locks_q[LOCK_SCROLL];
            else if (b == CODE_NUM) locks_q[LOCK_NUM] = ~locks_q[LOCK_NUM];
            else hit = key_event(b, 1'b1, ev);
         end
         PHASE_BREAK: begin
            if (!is_prefix) begin
               phase_q = PHASE_MAKE;
               if (b == CODE_LSHIFT) mods_q[MOD_LSHIFT] = 1'b0;
               else if (b == CODE_RSHIFT) mods_q[MOD_RSHIFT] = 1'b0;
               else if (b == CODE_CTRL) mods_q[MOD_LCTRL] = 1'b0;
               else hit = key_event(b, 1'b0, ev);
            end
         end
         PHASE_EXT_MAKE: begin
            if (is_prefix) phase_q = PHASE_EXT_BREAK;
            else begin
               phase_q = PHASE_MAKE;
               if (b == CODE_CTRL) mods_q[MOD_RCTRL] = 1'b1;
               else hit = key_event(b, 1'b1, ev);
            end
         end
         default: begin
            if (!is_prefix) begin
               phase_q = PHASE_MAKE;
               if (b == CODE_CTRL) mods_q[MOD_RCTRL] = 1'b0;
               else hit = key_event(b, 1'b0, ev);
            end
         end
      endcase
      return hit;
   endfunction

   // One line per mismatch, and count it
   task automatic report_mismatch(input string what);
      $display("[%0t] key check: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      key_report_type new_ev;
      key_report_type exp_ev;
      if (reset) begin
         phase_q = PHASE_MAKE;
         mods_q  = '0;
         locks_q = LOCK_RESET;
         key_events_q.delete();
      end else begin
         // accepted byte: predict
         if (req_valid && !req_stall) begin
            if (decode_byte(req_scan_byte, new_ev)) key_events_q.push_back(new_ev);
         end
         // accepted result transaction: compare with oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (key_events_q.size() == 0) begin
               report_mismatch($sformatf("unexpected event row %0d column %0d",
                                         rsp_key_row, rsp_key_column));
            end else begin
               exp_ev = key_events_q.pop_front();
               events_checked++;
               if (rsp_key_row !== exp_ev.row)
                  report_mismatch($sformatf("key_row %0d, want %0d",
                                            rsp_key_row, exp_ev.row));
               if (rsp_key_column !== exp_ev.column)
                  report_mismatch($sformatf("key_column %0d, want %0d (row %0d)",
                                            rsp_key_column, exp_ev.column, exp_ev.row));
               if (rsp_key_pressed !== exp_ev.pressed)
                  report_mismatch($sformatf("key_pressed %b, want %b (row %0d)",
                                            rsp_key_pressed, exp_ev.pressed, exp_ev.row));
               if (rsp_caps_state !== exp_ev.caps)
                  report_mismatch($sformatf("caps_state %b, want %b",
                                            rsp_caps_state, exp_ev.caps));
               if (rsp_num_state !== exp_ev.num)
                  report_mismatch($sformatf("num_state %b, want %b",
                                            rsp_num_state, exp_ev.num));
               if (rsp_scroll_state !== exp_ev.scroll)
                  report_mismatch($sformatf("scroll_state %b, want %b",
                                            rsp_scroll_state, exp_ev.scroll));
            end
         end
      end
      pending = key_events_q.size();
   end

endmodule

### sim/tb_ps2_scancode_key_decoder.sv
`timescale 1ns / 1ps

module tb_ps2_scancode_key_decoder;
   import pskd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int KEY_ROWS    = 59;

   // Known key codes, used to steer random bytes toward table hits
   localparam logic [7:0] KEY_CODES [KEY_ROWS] = '{
      8'h1c, 8'h32, 8'h21, 8'h23, 8'h24, 8'h2b, 8'h34, 8'h33, 8'h43, 8'h3b,
      8'h42, 8'h4b, 8'h3a, 8'h31, 8'h44, 8'h4d, 8'h15, 8'h2d, 8'h1b, 8'h2c,
      8'h3c, 8'h2a, 8'h1d, 8'h22, 8'h35, 8'h1a, 8'h45, 8'h16, 8'h1e, 8'h26,
      8'h25, 8'h2e, 8'h36, 8'h3d, 8'h3e, 8'h46, 8'h29, 8'h52, 8'h55, 8'h41,
      8'h4e, 8'h49, 8'h4a, 8'h4c, 8'h54, 8'h5d, 8'h5b, 8'h0e, 8'h75, 8'h72,
      8'h6b, 8'h74, 8'h0d, 8'h66, 8'h5a, 8'h6c, 8'h69, 8'h76, 8'h37
   };

   // Directed opening: extremes, prefixes, modifiers, locks, suppression
   localparam int DIRECTED_LEN = 29;
   localparam logic [7:0] DIRECTED_BYTES [DIRECTED_LEN] = '{
      8'h00, 8'hff, 8'h1c,
      CODE_BREAK, 8'h1c,
      CODE_LSHIFT, 8'h1c, CODE_BREAK, CODE_LSHIFT,
      CODE_CTRL, 8'h2b,
      CODE_CAPS, 8'h2b,
      CODE_BREAK, CODE_CAPS, CODE_CAPS,
      CODE_BREAK, CODE_CTRL,
      CODE_EXT, 8'h75,
      CODE_EXT, CODE_EXT, 8'h75,
      CODE_EXT, CODE_BREAK, CODE_BREAK, 8'h75,
      CODE_SCROLL, CODE_NUM
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_scan_byte = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [5:0] rsp_key_row;
   logic [1:0] rsp_key_column;
   logic       rsp_key_pressed;
   logic       rsp_caps_state;
   logic       rsp_num_state;
   logic       rsp_scroll_state;

   int mismatches;
   int pending;
   int events_checked;
   int items_sent = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   ps2_scancode_key_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_scan_byte    (req_scan_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_key_row      (rsp_key_row),
      .rsp_key_column   (rsp_key_column),
      .rsp_key_pressed  (rsp_key_pressed),
      .rsp_caps_state   (rsp_caps_state),
      .rsp_num_state    (rsp_num_state),
      .rsp_scroll_state (rsp_scroll_state)
   );

   pskd_key_checker key_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_scan_byte    (req_scan_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_key_row      (rsp_key_row),
      .rsp_key_column   (rsp_key_column),
      .rsp_key_pressed  (rsp_key_pressed),
      .rsp_caps_state   (rsp_caps_state),
      .rsp_num_state    (rsp_num_state),
      .rsp_scroll_state (rsp_scroll_state),
      .mismatches       (mismatches),
      .pending          (pending),
      .events_checked   (events_checked)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Receiver backpressure
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // One byte transaction, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_scan_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // Hold off the sender until every predicted event has come out
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Mostly well-formed keyboard traffic, some doubled prefixes and noise
   task automatic send_sequence();
      int         pick;
      int         reps;
      logic [7:0] key;
      pick = $urandom_range(99);
      if ($urandom_range(9) == 0) key = 8'($urandom_range(255));
      else key = KEY_CODES[$urandom_range(KEY_ROWS - 1)];
      if (pick < 35) begin
         if ($urandom_range(3) == 0) send_byte(CODE_EXT);
         send_byte(key);
      end else if (pick < 60) begin
         if ($urandom_range(3) == 0) send_byte(CODE_EXT);
         send_byte(CODE_BREAK);
         send_byte(key);
      end else if (pick < 72) begin
         // modifier press or release, ctrl sometimes the extended one
         case ($urandom_range(2))
            0: key = CODE_LSHIFT;
            1: key = CODE_RSHIFT;
            default: key = CODE_CTRL;
         endcase
         if (key == CODE_CTRL && $urandom_range(1) == 1) send_byte(CODE_EXT);
         if ($urandom_range(1) == 1) send_byte(CODE_BREAK);
         send_byte(key);
      end else if (pick < 80) begin
         case ($urandom_range(2))
            0: key = CODE_CAPS;
            1: key = CODE_NUM;
            default: key = CODE_SCROLL;
         endcase
         if ($urandom_range(3) == 0) send_byte(CODE_BREAK);
         send_byte(key);
      end else if (pick < 88) begin
         reps = $urandom_range(1, 3);
         repeat (reps) send_byte($urandom_range(1) == 1 ? CODE_BREAK : CODE_EXT);
         send_byte(key);
      end else begin
         send_byte(8'($urandom_range(255)));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender mostly busy, receiver mostly stalled
      send_idle_pct = 11;
      recv_stall_pct = 75;
      for (int i = 0; i < DIRECTED_LEN; i++) send_byte(DIRECTED_BYTES[i]);
      while (items_sent < 360) send_sequence();
      drain();

      // sender mostly idle, receiver mostly ready
      send_idle_pct = 75;
      recv_stall_pct = 11;
      while (items_sent < 690) send_sequence();
      drain();

      // full rate both ways
      send_idle_pct = 0;
      recv_stall_pct = 0;
      while (items_sent < 1020) send_sequence();
      drain();
      repeat (8) @(posedge clock);

      $display("tb: sent %0d scan bytes over three idle/stall mixes, directed part first",
               items_sent);
      $display("tb: %0d key events compared, %0d mismatches", events_checked, mismatches);
      if (mismatches == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
